// ----- rtl/rlrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rlrd_pkg: shared types and constants for the raster line RLE decoder
// Parser phase encoding, register indexes and stream framing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rlrd_pkg;

  // parser phase; code 3 is never entered and is treated like PH_PIXEL
  typedef enum logic [1:0] {
    PH_LINE  = 2'd0,   // expect line repeat byte
    PH_CODE  = 2'd1,   // expect run code
    PH_PIXEL = 2'd2    // collect pixel bytes
  } phase_t;

  // configuration register indexes
  localparam logic REG_WIDE_COMPONENTS = 1'b0;
  localparam logic REG_LINE_WIDTH      = 1'b1;

  localparam int CFG_DATA_W = 16;

  // bytes per pixel
  localparam logic [2:0] BPP_NARROW = 3'd3;
  localparam logic [2:0] BPP_WIDE   = 3'd6;

  // run codes at or above this are literal runs
  localparam logic [7:0] CODE_LITERAL_MIN = 8'd128;
  localparam logic [8:0] LITERAL_BASE     = 9'd257;

  // 16 -> 8 bit rounding offset: (v + 129) / 257
  localparam logic [16:0] ROUND_OFFSET = 17'd129;

  localparam int OUT_DATA_W = 48;

endpackage

`default_nettype wire

// ----- rtl/raster_line_rle_decoder_top.sv -----
// ----------------------------------------------------------------------------
// raster_line_rle_decoder_top: compressed raster byte stream to RGB pixel runs
// Parses line repeat bytes, run codes and pixel bytes; emits one result per
// decoded pixel with its clipped run length, line copy count and end of line.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: data_byte
//  out_    | out | out_tvalid/out_tready| out_tdata: red, green, blue,
//          |     |                      |   run_length, line_copies; tlast=eol
//  cfg_    | in  | cfg_wen              | cfg_index, cfg_wdata
//
//  One byte per cycle while in_tready is high: each request updates the parser
//  state in the same cycle, and a pixel-completing byte loads the output register
//  directly; out_tvalid rises in the cycle after the last byte of a pixel.
//  in_tready drops only when the byte would complete a pixel while the output
//  register still holds a result that is not taken; other bytes keep flowing.
//  Reset is synchronous (rst_n low); no clearing pass, ready right after.
//
`default_nettype none

module raster_line_rle_decoder_top
  import rlrd_pkg::*;
#(
  parameter int MAX_WIDTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,    // [7:0] data_byte

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] run_length,
  // [40:32] line_copies, [47:41] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,   // end_of_line

  input  wire logic                  cfg_wen,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // line width bits actually in use: the register is 16 bits wide
  localparam int WB = (MAX_WIDTH_BITS < 16) ? MAX_WIDTH_BITS : 16;

  // configuration
  logic                  wide_r;
  logic [CFG_DATA_W-1:0] line_width_r;

  // parser state
  phase_t        phase_r, phase_nxt;
  logic [2:0]    bip_r, bip_nxt;          // byte in pixel
  logic [15:0]   acc_r   [3];
  logic [15:0]   acc_nxt [3];
  logic          rep_r, rep_nxt;          // run is repeat
  logic [7:0]    lit_r, lit_nxt;          // literal pixels remaining
  logic [7:0]    rcnt_r, rcnt_nxt;        // repeat count
  logic [WB-1:0] pd_r, pd_nxt;            // pixels done in line
  logic [8:0]    copies_r, copies_nxt;

  // output register
  logic          ov_r;
  logic [7:0]    red_r, green_r, blue_r, run_q_r;
  logic [8:0]    lcop_r;
  logic          eol_r;

  // datapath
  logic          pixel_phase;
  logic [2:0]    bpp;
  logic [2:0]    bip_inc;
  logic          emit;
  logic          fire;
  logic [WB-1:0] w_eff;
  logic [WB-1:0] rem;
  logic [7:0]    run_base;
  logic [7:0]    run_c;
  logic [WB:0]   pd_sum;
  logic          eol_c;
  logic [7:0]    lit_dec;

  // (v + 129) / 257 via q1 = x >> 8 and one correction (q1 - q <= 1)
  function automatic logic [7:0] to8(input logic wide, input logic [15:0] v);
    logic [16:0] x;
    logic [8:0]  q1;
    logic [8:0]  q;
    x  = {1'b0, v} + ROUND_OFFSET;
    q1 = x[16:8];
    q  = q1 - {8'd0, ({1'b0, x[7:0]} < q1)};
    return wide ? q[7:0] : v[7:0];
  endfunction

  assign pixel_phase = (phase_r != PH_LINE) && (phase_r != PH_CODE);
  assign bpp         = wide_r ? BPP_WIDE : BPP_NARROW;
  assign bip_inc     = bip_r + 3'd1;
  assign emit        = pixel_phase && (bip_inc >= bpp);

  // a byte that yields no pixel never waits on the output side
  assign in_tready = !emit || !ov_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  // zero width behaves as width 1
  assign w_eff    = (line_width_r[WB-1:0] == '0) ? WB'(1) : line_width_r[WB-1:0];
  assign rem      = w_eff - pd_r;
  assign run_base = rep_r ? rcnt_r : 8'd1;

  always_comb begin
    if (pd_r < w_eff) begin
      run_c = (WB'(run_base) > rem) ? rem[7:0] : run_base;
    end else begin
      // width lowered under the current position: close the line
      run_c = 8'd1;
    end
  end

  assign pd_sum  = {1'b0, pd_r} + (WB+1)'(run_c);
  assign eol_c   = pd_sum >= {1'b0, w_eff};
  assign lit_dec = lit_r - 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        PH_LINE: phase_nxt = PH_CODE;
        PH_CODE: phase_nxt = PH_PIXEL;
        default: begin
          if (emit) begin
            if (eol_c) begin
              phase_nxt = PH_LINE;
            end else if (rep_r) begin
              phase_nxt = PH_CODE;
            end else begin
              phase_nxt = (lit_dec == 8'd0) ? PH_CODE : PH_PIXEL;
            end
          end
        end
      endcase
    end
  end

  // parser datapath
  always_comb begin
    bip_nxt    = bip_r;
    acc_nxt    = acc_r;
    rep_nxt    = rep_r;
    lit_nxt    = lit_r;
    rcnt_nxt   = rcnt_r;
    pd_nxt     = pd_r;
    copies_nxt = copies_r;

    // component capture; also feeds the output register on the last byte
    if (pixel_phase) begin
      if (wide_r) begin
        if (bip_r < BPP_WIDE) begin
          if (bip_r[0]) begin
            acc_nxt[bip_r[2:1]] = {in_tdata, acc_r[bip_r[2:1]][7:0]};
          end else begin
            acc_nxt[bip_r[2:1]] = {acc_r[bip_r[2:1]][15:8], in_tdata};
          end
        end
      end else if (bip_r < BPP_NARROW) begin
        acc_nxt[bip_r[1:0]] = {8'd0, in_tdata};
      end
    end

    case (phase_r)
      PH_LINE: begin
        copies_nxt = {1'b0, in_tdata} + 9'd1;
        pd_nxt     = '0;
        bip_nxt    = 3'd0;
      end
      PH_CODE: begin
        if (in_tdata < CODE_LITERAL_MIN) begin
          rep_nxt  = 1'b1;
          rcnt_nxt = in_tdata + 8'd1;
        end else begin
          rep_nxt = 1'b0;
          lit_nxt = 8'(LITERAL_BASE - {1'b0, in_tdata});
        end
        bip_nxt = 3'd0;
      end
      default: begin
        if (!emit) begin
          bip_nxt = bip_inc;
        end else begin
          bip_nxt = 3'd0;
          if (eol_c) begin
            pd_nxt  = '0;
            lit_nxt = 8'd0;
          end else begin
            pd_nxt = pd_sum[WB-1:0];
            if (!rep_r) begin
              lit_nxt = lit_dec;
            end
          end
        end
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r       <= 1'b0;
      line_width_r <= CFG_DATA_W'(640);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_WIDE_COMPONENTS: wide_r       <= cfg_wdata[0];
        REG_LINE_WIDTH:      line_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LINE;
      bip_r    <= 3'd0;
      acc_r[0] <= 16'd0;
      acc_r[1] <= 16'd0;
      acc_r[2] <= 16'd0;
      rep_r    <= 1'b0;
      lit_r    <= 8'd0;
      rcnt_r   <= 8'd0;
      pd_r     <= '0;
      copies_r <= 9'd1;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      bip_r    <= bip_nxt;
      acc_r    <= acc_nxt;
      rep_r    <= rep_nxt;
      lit_r    <= lit_nxt;
      rcnt_r   <= rcnt_nxt;
      pd_r     <= pd_nxt;
      copies_r <= copies_nxt;
    end
  end

  // output register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (fire && emit) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      red_r   <= to8(wide_r, acc_nxt[0]);
      green_r <= to8(wide_r, acc_nxt[1]);
      blue_r  <= to8(wide_r, acc_nxt[2]);
      run_q_r <= run_c;
      lcop_r  <= copies_r;
      eol_r   <= eol_c;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, lcop_r, run_q_r, blue_r, green_r, red_r};
  assign out_tlast  = eol_r;

  // ---- checks ----
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && emit && ov_r && !out_tready))
    else $error("result register overwritten while stalled");

  a_eol_to_line: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && eol_c) |=> (phase_r == PH_LINE))
    else $error("end of line did not return to repeat byte");

  a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
    bip_r < BPP_WIDE)
    else $error("byte in pixel out of range");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (run_q_r != 8'd0) && (lcop_r != 9'd0))
    else $error("zero run length or copy count");

  a_pd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && !eol_c) |=> (pd_r < w_eff))
    else $error("pixel position passed line end without end of line");

endmodule

`default_nettype wire
